[rtl/core/mxrm_pkg.sv]
// ----------------------------------------------------------------------------
// mxrm_pkg
// shared widths, types and register codes of the modular exponentiation block
// ----------------------------------------------------------------------------
package mxrm_pkg;

    localparam int MODULUS_BITS = 16;
    localparam int WORD_W       = MODULUS_BITS;
    localparam int EXP_W        = 8;
    localparam int SUM_W        = WORD_W + 2;
    localparam int CNT_W        = $clog2(WORD_W + 1);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = WORD_W;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [EXP_W-1:0]     exp_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // register indexes of the configuration port
    localparam cfg_idx_t REG_MODULUS  = CFG_IDX_W'(0);
    localparam cfg_idx_t REG_EXPONENT = CFG_IDX_W'(1);

    localparam word_t MODULUS_RESET  = WORD_W'(3127);
    localparam exp_t  EXPONENT_RESET = EXP_W'(0);

    // status of the serial multiplier toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

[rtl/core/mxrm_mulmod.sv]
// ----------------------------------------------------------------------------
// mxrm_mulmod
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mxrm_mulmod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mxrm_pkg::word_t     a,
    input  mxrm_pkg::word_t     b,
    input  mxrm_pkg::word_t     m,
    output mxrm_pkg::mm_status_t status,
    output mxrm_pkg::word_t     result
);
    import mxrm_pkg::*;

    logic  busy_reg;
    logic  done_reg;
    cnt_t  cnt_reg;
    word_t a_reg;
    word_t m_reg;
    word_t b_sh_reg;
    word_t r_reg;
    word_t r_next;

    sum_t  t;
    sum_t  m1;
    sum_t  m2;
    sum_t  red;

    // r = 2r + bit*a, then bring back below m (t < 3m since r < m and a <= m)
    always_comb
    begin
        t   = {1'b0, r_reg, 1'b0} + (b_sh_reg[WORD_W-1] ? {2'b00, a_reg} : '0);
        m1  = {2'b00, m_reg};
        m2  = {1'b0, m_reg, 1'b0};
        if (t >= m2)
        begin
            red = t - m2;
        end
        else if (t >= m1)
        begin
            red = t - m1;
        end
        else
        begin
            red = t;
        end
        r_next = red[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            m_reg    <= m;
            b_sh_reg <= b;
            r_reg    <= '0;
        end
        else if (busy_reg)
        begin
            r_reg    <= r_next;
            b_sh_reg <= {b_sh_reg[WORD_W-2:0], 1'b0};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = r_reg;

endmodule

[rtl/core/modular_exponentiation_repeated_multiply.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_repeated_multiply
// message^exponent mod modulus by repeated bit-serial multiply-reduce steps
// ----------------------------------------------------------------------------
// Each input beat carries one 16-bit message; one output beat returns
// cipher = message^exponent mod modulus. The running value starts at 1 and is
// multiplied by the message and reduced exponent times; an exponent of 0
// returns 1 (even for modulus 1). Each multiply-reduce step runs in a
// bit-serial multiplier that consumes one message bit per cycle; a step is
// the start strobe, the message bit steps and the done strobe in that order,
// and the next message is taken once the result is in the output register.
// One message is in work at a time; the result sits in an output register so
// a new message can be taken while it waits.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 modulus,
// 1 exponent, low 8 bits) at the clock edge; a modulus written as 0 is held
// as 1. Write only while the block is idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_repeated_multiply (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  mxrm_pkg::cfg_idx_t    cfg_index,
    input  mxrm_pkg::cfg_data_t   cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] message
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata    // [15:0] cipher
);
    import mxrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t     state_reg;
    state_t     state_next;

    // configuration registers
    word_t      modulus_reg;
    exp_t       exponent_reg;

    // working registers
    word_t      acc_reg;
    word_t      acc_next;
    word_t      msg_reg;
    exp_t       step_reg;
    exp_t       step_next;
    logic       start_reg;
    logic       start_next;

    // output register
    logic       out_valid_reg;
    word_t      out_data_reg;

    mm_status_t mm_status;
    word_t      mm_result;

    logic       in_beat;
    logic       out_load;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    // result moves to the output register once it is empty or being drained
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    // configuration writes, modulus zero held as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            exponent_reg <= EXPONENT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS:
                begin
                    modulus_reg <= (cfg_wdata[WORD_W-1:0] == '0) ? WORD_W'(1)
                                                                 : cfg_wdata[WORD_W-1:0];
                end
                REG_EXPONENT:
                begin
                    exponent_reg <= cfg_wdata[EXP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // step sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        start_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    acc_next  = WORD_W'(1);
                    step_next = exponent_reg;
                    if (exponent_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                        start_next = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_status.done)
                begin
                    acc_next  = mm_result;
                    step_next = step_reg - EXP_W'(1);
                    if (step_reg == EXP_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        start_next = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            step_reg  <= step_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_beat)
        begin
            msg_reg <= s_axis_tdata;
        end
        if (out_load)
        begin
            out_data_reg <= acc_reg;
        end
    end

    // acc is always at most the modulus, as the multiplier needs
    mxrm_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .a      (acc_reg),
        .b      (msg_reg),
        .m      (modulus_reg),
        .status (mm_status),
        .result (mm_result)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    // the multiplier only runs while a message is in work
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!mm_status.busy && !mm_status.done))
        else $error("multiplier active while sequencer idle");

    // a finished step always finds the sequencer waiting for it
    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mm_status.done |-> (state_reg == S_MUL))
        else $error("multiplier done outside multiply state");

    // steps remain whenever a multiply is under way
    a_steps_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (step_reg != '0))
        else $error("multiply state with no steps left");

    // a start never lands on a running multiplier
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !mm_status.busy)
        else $error("multiplier restarted while busy");
`endif

endmodule
